// ===== rtl/bdip_pkg.sv =====
// shared types and constants of the box-average image pyramid
package bdip_pkg;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 9;
  localparam int CNT_W      = 10;
  localparam int DIM_W      = 11;
  localparam int LVL_W      = 3;
  localparam int PAIR_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int MAX_HEIGHT = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_PYRAMID_LEVELS = 2'd2
  } cfg_reg_t;

  // input request payload
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_t;

  // result request payload
  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic [PIX_W-1:0] value;
    logic             last_of_run;
  } res_t;

  // token handed from one cell to the next
  typedef struct packed {
    logic             valid;
    logic             frame_start;
    logic             pix_valid;
    logic [PIX_W-1:0] pix;
  } link_t;

  // clamped frame geometry
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [LVL_W-1:0] levels;
  } geom_t;

endpackage

// ===== rtl/bdip_cell.sv =====
// one pyramid level: position counters, held pixel, pair-sum line and 2x2 average
module bdip_cell #(
  parameter int LEVEL     = 0,
  parameter int MAX_WIDTH = 1024,
  parameter int SLOTS     = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bdip_pkg::geom_t               geom,
  input  bdip_pkg::link_t               link_in,
  input  bdip_pkg::res_t [SLOTS-1:0]    slots_in,
  input  logic [SLOTS-1:0]              slot_valid_in,
  output bdip_pkg::link_t               link_out,
  output bdip_pkg::res_t [SLOTS-1:0]    slots_out,
  output logic [SLOTS-1:0]              slot_valid_out
);

  localparam int DEPTH_RAW = MAX_WIDTH >> (LEVEL + 1);
  localparam int DEPTH     = (DEPTH_RAW < 2) ? 2 : DEPTH_RAW;
  localparam int AW        = $clog2(DEPTH);

  logic [bdip_pkg::CNT_W-1:0]  col;
  logic [bdip_pkg::CNT_W-1:0]  row;
  logic [bdip_pkg::CNT_W-1:0]  col_next;
  logic [bdip_pkg::CNT_W-1:0]  row_next;
  logic [bdip_pkg::PIX_W-1:0]  held;
  logic                        valid_q;
  logic                        fs_q;
  logic                        prod_q;
  logic [bdip_pkg::PAIR_W-1:0] pair_q;
  logic [bdip_pkg::PAIR_W-1:0] rdata;
  logic [bdip_pkg::PAIR_W-1:0] line_mem [DEPTH];
  bdip_pkg::res_t [SLOTS-1:0]  slots_q;
  bdip_pkg::res_t [SLOTS-1:0]  slots_next;
  logic [SLOTS-1:0]            svalid_q;
  logic [SLOTS-1:0]            svalid_next;

  logic [bdip_pkg::DIM_W-1:0]  wl;
  logic [bdip_pkg::DIM_W-1:0]  hl;
  logic                        start;
  logic [bdip_pkg::CNT_W-1:0]  col_eff;
  logic [bdip_pkg::CNT_W-1:0]  row_eff;
  logic                        can_prod;
  logic                        in_win;
  logic                        act;
  logic [bdip_pkg::PAIR_W-1:0] pair;
  logic [bdip_pkg::CNT_W+AW-1:0] col_ext;
  logic [AW-1:0]               idx;
  logic                        wr_en;
  logic                        rd_en;
  logic [bdip_pkg::DIM_W-1:0]  col_inc;
  logic [bdip_pkg::DIM_W-1:0]  row_inc;
  logic [bdip_pkg::PAIR_W:0]   quad;

  assign wl       = geom.width >> LEVEL;
  assign hl       = geom.height >> LEVEL;
  assign start    = link_in.valid & link_in.frame_start;
  assign col_eff  = start ? '0 : col;
  assign row_eff  = start ? '0 : row;
  assign can_prod = (LEVEL + 1) < int'(geom.levels);
  // trailing odd column and row stay out of the averaging window
  assign in_win   = ({1'b0, col_eff} < {wl[bdip_pkg::DIM_W-1:1], 1'b0}) &&
                    ({1'b0, row_eff} < {hl[bdip_pkg::DIM_W-1:1], 1'b0});
  assign act      = link_in.pix_valid & can_prod & in_win;
  assign pair     = {1'b0, held} + {1'b0, link_in.pix};
  assign col_ext  = {{AW{1'b0}}, col_eff};
  assign idx      = col_ext[AW:1];
  assign wr_en    = act & col_eff[0] & ~row_eff[0];
  assign rd_en    = act & col_eff[0] & row_eff[0];
  assign col_inc  = {1'b0, col_eff} + 11'd1;
  assign row_inc  = {1'b0, row_eff} + 11'd1;

  always_comb begin
    col_next = col_eff;
    row_next = row_eff;
    if (link_in.pix_valid) begin
      if (col_inc >= wl) begin
        col_next = '0;
        if (row_inc >= hl) begin
          row_next = '0;
        end else begin
          row_next = row_inc[bdip_pkg::CNT_W-1:0];
        end
      end else begin
        col_next = col_inc[bdip_pkg::CNT_W-1:0];
      end
    end
  end

  generate
    if (LEVEL > 0) begin : g_emit
      // a pixel arriving here is a result of this level at the current position
      always_comb begin
        slots_next  = slots_in;
        svalid_next = slot_valid_in;
        if (link_in.pix_valid) begin
          slots_next[LEVEL-1].level       = bdip_pkg::LVL_W'(LEVEL);
          slots_next[LEVEL-1].column      = col_eff[bdip_pkg::POS_W-1:0];
          slots_next[LEVEL-1].row         = row_eff[bdip_pkg::POS_W-1:0];
          slots_next[LEVEL-1].value       = link_in.pix;
          slots_next[LEVEL-1].last_of_run = 1'b0;
          svalid_next[LEVEL-1]            = 1'b1;
        end
      end
    end else begin : g_pass
      always_comb begin
        slots_next  = slots_in;
        svalid_next = slot_valid_in;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      col     <= '0;
      row     <= '0;
      held    <= '0;
    end else begin
      valid_q <= link_in.valid;
      col     <= col_next;
      row     <= row_next;
      if (act && !col_eff[0]) begin
        held <= link_in.pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    fs_q     <= link_in.frame_start;
    prod_q   <= rd_en;
    pair_q   <= pair;
    slots_q  <= slots_next;
    svalid_q <= svalid_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[idx] <= pair;
    end
    if (rd_en) begin
      rdata <= line_mem[idx];
    end
  end

  assign quad                 = {1'b0, pair_q} + {1'b0, rdata};
  assign link_out.valid       = valid_q;
  assign link_out.frame_start = fs_q;
  assign link_out.pix_valid   = valid_q & prod_q;
  assign link_out.pix         = quad[bdip_pkg::PAIR_W:2];
  assign slots_out            = slots_q;
  assign slot_valid_out       = svalid_q;

endmodule

// ===== rtl/bdip_outq.sv =====
// result queue: holds per-pixel result groups and sends them out one result at a time
module bdip_outq #(
  parameter int SLOTS   = 4,
  parameter int DEPTH   = 16,
  parameter int RESERVE = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bdip_pkg::res_t [SLOTS-1:0] slots_in,
  input  logic [SLOTS-1:0]           slot_valid_in,
  output logic                       res_valid,
  input  logic                       res_stall,
  output bdip_pkg::res_t             res_data,
  output logic                       nearly_full
);

  localparam int PW = $clog2(DEPTH);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [PW:0] LIMIT = (PW+1)'(DEPTH - RESERVE);

  bdip_pkg::res_t [SLOTS-1:0] grp_mem [DEPTH];
  logic [SLOTS-1:0]           gv_mem  [DEPTH];
  logic [PW-1:0]              wr_ptr;
  logic [PW-1:0]              rd_ptr;
  logic [PW:0]                count;
  logic [SW-1:0]              sel;
  bdip_pkg::res_t [SLOTS-1:0] head;
  logic [SLOTS-1:0]           head_valid;
  logic [SLOTS:0]             more;
  logic                       last;
  logic                       take;
  logic                       pop;

  assign head       = grp_mem[rd_ptr];
  assign head_valid = gv_mem[rd_ptr];
  assign more       = {1'b0, head_valid} >> sel;
  assign last       = ~more[1];
  assign res_valid  = (count != '0);
  assign take       = res_valid & ~res_stall;
  assign pop        = take & last;
  assign nearly_full = (count >= LIMIT);

  always_comb begin
    res_data             = head[sel];
    res_data.last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      grp_mem[wr_ptr] <= slots_in;
      gv_mem[wr_ptr]  <= slot_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sel    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
        sel    <= '0;
      end else if (take) begin
        sel <= sel + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ===== rtl/box_downsample_image_pyramid.sv =====
// top level of the streaming 2x2 box-average image pyramid
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  pix     | in        | pix_valid / pix_stall  | pixel, frame_start
//  res     | out       | res_valid / res_stall  | level, column, row, value, last_of_run
//  cfg     | in        | cfg_write              | cfg_index, cfg_data (no read-back)
//
// one pixel request is taken every cycle while pix_stall is low; it walks a row
// of MAX_LEVELS cells, each registering it; its results are queued from the last cell
// the result port sends one result per cycle from the queue head while res_stall is low
// pix_stall rises once RESERVE or fewer queue entries are free, room for all in cells
// synchronous reset clears counters, held pixels and the queue; the line stores
// need no clearing as an entry is always written on an even row before it is read
module box_downsample_image_pyramid #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_LEVELS = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pix_valid,
  output logic                               pix_stall,
  input  bdip_pkg::pix_t                     pix_data,
  output logic                               res_valid,
  input  logic                               res_stall,
  output bdip_pkg::res_t                     res_data,
  input  logic                               cfg_write,
  input  logic [bdip_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdip_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // one result slot per level below level zero
  localparam int SLOTS   = MAX_LEVELS - 1;
  // queue keeps room for every request that may still be inside the cells
  localparam int RESERVE = MAX_LEVELS + 1;
  localparam int QDEPTH  = 1 << $clog2(2 * MAX_LEVELS + 4);

  // configuration registers, raw as written
  logic [bdip_pkg::DIM_W-1:0] width_reg;
  logic [bdip_pkg::DIM_W-1:0] height_reg;
  logic [bdip_pkg::LVL_W-1:0] levels_reg;
  bdip_pkg::geom_t            geom;

  // chain wiring between cells
  bdip_pkg::link_t            links     [MAX_LEVELS+1];
  bdip_pkg::res_t [SLOTS-1:0] slot_bus  [MAX_LEVELS+1];
  logic [SLOTS-1:0]           valid_bus [MAX_LEVELS+1];

  logic accept;
  logic push;
  logic nearly_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 11'd640;
      height_reg <= 11'd480;
      levels_reg <= 3'd4;
    end else if (cfg_write) begin
      case (cfg_index)
        bdip_pkg::REG_IMAGE_WIDTH:    width_reg  <= cfg_data;
        bdip_pkg::REG_IMAGE_HEIGHT:   height_reg <= cfg_data;
        bdip_pkg::REG_PYRAMID_LEVELS: levels_reg <= cfg_data[bdip_pkg::LVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp the registers into the supported geometry
  always_comb begin
    geom.width  = width_reg;
    geom.height = height_reg;
    geom.levels = levels_reg;
    if (width_reg < 11'd2) begin
      geom.width = 11'd2;
    end else if (int'(width_reg) > MAX_WIDTH) begin
      geom.width = bdip_pkg::DIM_W'(MAX_WIDTH);
    end
    if (height_reg < 11'd2) begin
      geom.height = 11'd2;
    end else if (int'(height_reg) > bdip_pkg::MAX_HEIGHT) begin
      geom.height = bdip_pkg::DIM_W'(bdip_pkg::MAX_HEIGHT);
    end
    if (levels_reg == '0) begin
      geom.levels = 3'd1;
    end else if (int'(levels_reg) > MAX_LEVELS) begin
      geom.levels = bdip_pkg::LVL_W'(MAX_LEVELS);
    end
  end

  assign pix_stall = nearly_full;
  assign accept    = pix_valid & ~pix_stall;

  // level zero is fed straight from the pixel request
  assign links[0].valid       = accept;
  assign links[0].frame_start = pix_data.frame_start;
  assign links[0].pix_valid   = accept;
  assign links[0].pix         = pix_data.pixel;
  assign slot_bus[0]          = '0;
  assign valid_bus[0]         = '0;

  // one cell per level; a finished average moves on to the next level cell
  generate
    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
      bdip_cell #(
        .LEVEL     (g),
        .MAX_WIDTH (MAX_WIDTH),
        .SLOTS     (SLOTS)
      ) u_cell (
        .clk            (clk),
        .rst            (rst),
        .geom           (geom),
        .link_in        (links[g]),
        .slots_in       (slot_bus[g]),
        .slot_valid_in  (valid_bus[g]),
        .link_out       (links[g+1]),
        .slots_out      (slot_bus[g+1]),
        .slot_valid_out (valid_bus[g+1])
      );
    end
  endgenerate

  // a request leaving the last cell carries all of its results; empty groups are dropped
  assign push = links[MAX_LEVELS].valid & valid_bus[MAX_LEVELS][0];

  bdip_outq #(
    .SLOTS   (SLOTS),
    .DEPTH   (QDEPTH),
    .RESERVE (RESERVE)
  ) u_outq (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .slots_in      (slot_bus[MAX_LEVELS]),
    .slot_valid_in (valid_bus[MAX_LEVELS]),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res_data      (res_data),
    .nearly_full   (nearly_full)
  );

endmodule

// ===== tb/sv/box_downsample_image_pyramid_checker.sv =====
// checker for the box-average image pyramid: folds accepted pixels into expected results
module box_downsample_image_pyramid_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_LEVELS = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  input  logic                                pix_stall,
  input  bdip_pkg::pix_t                      pix_data,
  input  logic                                res_valid,
  input  logic                                res_stall,
  input  bdip_pkg::res_t                      res_data,
  input  logic                                cfg_write,
  input  logic [bdip_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdip_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int unsigned                         fail_count,
  output int unsigned                         pending
);

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int RESET_LEVELS = 4;

  logic [bdip_pkg::DIM_W-1:0]  width_reg;
  logic [bdip_pkg::DIM_W-1:0]  height_reg;
  logic [bdip_pkg::LVL_W-1:0]  levels_reg;
  logic [bdip_pkg::PIX_W-1:0]  held_pix [MAX_LEVELS];
  logic [bdip_pkg::CNT_W-1:0]  col_at [MAX_LEVELS];
  logic [bdip_pkg::CNT_W-1:0]  row_at [MAX_LEVELS];
  logic [bdip_pkg::PAIR_W-1:0] pair_line [MAX_LEVELS][MAX_WIDTH/2];
  bdip_pkg::res_t              due_pixels [$];
  bdip_pkg::res_t              head;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("pyramid check: %s got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // one level-0 pixel, cascading down while each level completes a 2x2 block
  task automatic fold_pixel(input bdip_pkg::pix_t req);
    int unsigned    w0, h0, depth, wl, hl, c, r, pair, cur, nxt, n, lv, k;
    bit             made;
    bdip_pkg::res_t run [MAX_LEVELS];
    w0    = clamp_to(width_reg, 2, MAX_WIDTH);
    h0    = clamp_to(height_reg, 2, bdip_pkg::MAX_HEIGHT);
    depth = clamp_to(levels_reg, 1, MAX_LEVELS);
    cur   = req.pixel;
    n     = 0;
    if (req.frame_start) begin
      for (k = 0; k < MAX_LEVELS; k++) begin
        col_at[k] = '0;
        row_at[k] = '0;
      end
    end
    for (lv = 0; lv < depth; lv++) begin
      wl   = w0 >> lv;
      hl   = h0 >> lv;
      c    = col_at[lv];
      r    = row_at[lv];
      made = 1'b0;
      nxt  = 0;
      // trailing odd column or row of a level takes no part
      if (lv + 1 < depth && c < (wl & ~32'd1) && r < (hl & ~32'd1)) begin
        if (!c[0]) begin
          held_pix[lv] = cur[bdip_pkg::PIX_W-1:0];
        end else begin
          pair = held_pix[lv] + cur;
          if (!r[0]) begin
            pair_line[lv][c >> 1] = pair[bdip_pkg::PAIR_W-1:0];
          end else begin
            nxt  = ((pair + pair_line[lv][c >> 1]) >> 2) & 32'hFF;
            made = 1'b1;
          end
        end
      end
      // position wraps at the level edges so frames can run back to back
      c++;
      if (c >= wl) begin
        c = 0;
        r++;
        if (r >= hl) r = 0;
      end
      col_at[lv] = c[bdip_pkg::CNT_W-1:0];
      row_at[lv] = r[bdip_pkg::CNT_W-1:0];
      if (!made) break;
      run[n].level       = bdip_pkg::LVL_W'(lv + 1);
      run[n].column      = col_at[lv + 1][bdip_pkg::POS_W-1:0];
      run[n].row         = row_at[lv + 1][bdip_pkg::POS_W-1:0];
      run[n].value       = nxt[bdip_pkg::PIX_W-1:0];
      run[n].last_of_run = 1'b0;
      n++;
      cur = nxt;
    end
    if (n > 0) run[n - 1].last_of_run = 1'b1;
    for (k = 0; k < n; k++) due_pixels.insert(due_pixels.size(), run[k]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  <= bdip_pkg::DIM_W'(RESET_WIDTH);
      height_reg <= bdip_pkg::DIM_W'(RESET_HEIGHT);
      levels_reg <= bdip_pkg::LVL_W'(RESET_LEVELS);
      for (int i = 0; i < MAX_LEVELS; i++) begin
        held_pix[i] <= '0;
        col_at[i]   <= '0;
        row_at[i]   <= '0;
      end
      due_pixels.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (due_pixels.size() == 0) begin
          report_mismatch("result with nothing due, level", res_data.level, 0);
        end else begin
          head = due_pixels.pop_front();
          if (res_data.level != head.level)
            report_mismatch("level", res_data.level, head.level);
          if (res_data.column != head.column)
            report_mismatch("column", res_data.column, head.column);
          if (res_data.row != head.row)
            report_mismatch("row", res_data.row, head.row);
          if (res_data.value != head.value)
            report_mismatch("value", res_data.value, head.value);
          if (res_data.last_of_run != head.last_of_run)
            report_mismatch("last_of_run", res_data.last_of_run, head.last_of_run);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          bdip_pkg::REG_IMAGE_WIDTH:    width_reg  = cfg_data;
          bdip_pkg::REG_IMAGE_HEIGHT:   height_reg = cfg_data;
          bdip_pkg::REG_PYRAMID_LEVELS: levels_reg = cfg_data[bdip_pkg::LVL_W-1:0];
          default: ;
        endcase
      end
      if (pix_valid && !pix_stall) fold_pixel(pix_data);
      pending <= due_pixels.size();
    end
  end

endmodule

// ===== tb/sv/box_downsample_image_pyramid_tb.sv =====
// testbench top: stimulus, receiver back-pressure and verdict for the image pyramid
module box_downsample_image_pyramid_tb;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_LEVELS = 5;
  // settling wait after the last result has left, for the cells to empty
  localparam int SETTLE     = 2 * MAX_LEVELS + 4;
  localparam int HOLD_LEN   = 500;
  localparam int RAND_ITEMS = 100;
  localparam int CALM_ITEMS = 60;
  localparam int EDGE_ITEMS = 24;
  localparam int LADDER     = 16;

  logic                                clk;
  logic                                rst;
  logic                                pix_valid;
  logic                                pix_stall;
  bdip_pkg::pix_t                      pix_data;
  logic                                res_valid;
  logic                                res_stall;
  bdip_pkg::res_t                      res_data;
  logic                                cfg_write;
  logic [bdip_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [bdip_pkg::CFG_DATA_W-1:0]     cfg_data;

  int unsigned fail_count;
  int unsigned pending;

  // calm: neither side idles; hold_go: receiver starts its long hold-off
  bit          calm;
  bit          hold_go;
  bit          hold_done;
  int unsigned hold_left;

  box_downsample_image_pyramid #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LEVELS(MAX_LEVELS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix_data (pix_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  box_downsample_image_pyramid_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LEVELS(MAX_LEVELS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, one long hold-off on request, none while calm
  initial begin
    res_stall = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= !calm && ($urandom_range(99) < 24);
      end
    end
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned span(int unsigned raw);
    if (raw < 2) return 2;
    if (raw > MAX_WIDTH) return MAX_WIDTH;
    return raw;
  endfunction

  // offer one pixel request and hold it until it is taken
  task automatic send_pixel(input logic [bdip_pkg::PIX_W-1:0] p, input logic fs);
    while (!calm && $urandom_range(99) < 24) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid            <= 1'b1;
    pix_data.pixel       <= p;
    pix_data.frame_start <= fs;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  // a run of pixels, extremes mixed in; noisy adds stray frame starts
  task automatic run_frame(input int unsigned count, input bit mark_start, input bit noisy);
    int unsigned                i;
    logic [bdip_pkg::PIX_W-1:0] p;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       p = '0;
        1:       p = '1;
        default: p = bdip_pkg::PIX_W'($urandom_range(255));
      endcase
      send_pixel(p, (i == 0 && mark_start) || (noisy && $urandom_range(39) == 0));
    end
  endtask

  // let every due result drain, then give the cells time to empty
  task automatic drain;
    pix_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // registers are written back to back, only while the block is idle
  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned lv);
    cfg_write <= 1'b1;
    cfg_index <= bdip_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= bdip_pkg::CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= bdip_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= bdip_pkg::CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= bdip_pkg::REG_PYRAMID_LEVELS;
    cfg_data  <= bdip_pkg::CFG_DATA_W'(lv);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned w, h, lv, len, frames, fed, f;
    rst       = 1'b1;
    pix_valid = 1'b0;
    pix_data  = '0;
    cfg_write = 1'b0;
    cfg_index = bdip_pkg::REG_IMAGE_WIDTH;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_go   = 1'b0;
    fed       = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: a couple of pixels, far too few to finish a block
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b0);
    drain();

    // width and height below range clamp to 2, two levels
    set_geometry(0, 1, 2);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b0);
    // next frame follows by wrap alone, sum truncates to zero
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h03, 1'b0);
    // truncation of an odd total
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFE, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b0);
    // frame start mid-frame, then again on the very next pixel
    send_pixel(8'h07, 1'b0);
    send_pixel(8'h07, 1'b1);
    send_pixel(8'h09, 1'b1);
    send_pixel(8'h0B, 1'b0);
    send_pixel(8'h0D, 1'b0);
    send_pixel(8'h0F, 1'b0);
    drain();

    // zero levels clamps to one: pixels go in, nothing comes out
    set_geometry(5, 3, 0);
    run_frame(6, 1'b1, 1'b0);

    // random geometry phases, mostly small whole frames, some cut short
    calm <= 1'b1;
    while (fed < RAND_ITEMS) begin
      drain();
      w  = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(2, 12);
      h  = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(2, 12);
      lv = $urandom_range(7);
      set_geometry(w, h, lv);
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames && fed < RAND_ITEMS; f++) begin
        len = span(w) * span(h);
        if (len > 64 || $urandom_range(3) == 0) begin
          len = $urandom_range(1, (len > 64) ? 64 : len);
        end
        if (len > RAND_ITEMS - fed) len = RAND_ITEMS - fed;
        // the first frame after a register change always marks its start
        run_frame(len, f == 0 || $urandom_range(3) != 0, 1'b1);
        fed += len;
      end
      calm <= (fed < CALM_ITEMS);
    end
    drain();

    // width and levels above range clamp to the widest line and deepest pyramid
    set_geometry(2047, 2, 7);
    run_frame(EDGE_ITEMS, 1'b1, 1'b0);
    drain();

    // 16x16 over five levels reaches level 4; receiver holds off meanwhile
    set_geometry(LADDER, LADDER, 5);
    hold_go <= 1'b1;
    run_frame(LADDER * LADDER, 1'b1, 1'b0);
    drain();

    // height above range clamps to the tallest frame
    set_geometry(2, 2047, 3);
    run_frame(EDGE_ITEMS, 1'b1, 1'b0);

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
